// ===== rtl/lmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// LED matrix column scanner package
// Shared types and constants for the 8x8 RGB column scan driver.
// ----------------------------------------------------------------------------
package lmcs_pkg;

  // Operation codes of an input request
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SCAN  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  // Color slot inside a stored row word, blue shifts out first
  localparam logic [1:0] COLOR_RED   = 2'd0;
  localparam logic [1:0] COLOR_GREEN = 2'd1;
  localparam logic [1:0] COLOR_BLUE  = 2'd2;

  // Matrix geometry
  localparam int unsigned SIDE      = 8;
  localparam int unsigned COORD_W   = 3;
  localparam int unsigned ROW_WORDS = SIDE * SIDE;
  localparam int unsigned PAGE_W    = 4;
  localparam int unsigned PIXEL_W   = 24;

  // 144 gamma bits with data high, eight per byte
  localparam int unsigned GAMMA_BYTES = (SIDE * 3 * 6) / 8;

  // One result as handed from the sequencer to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] shift_byte;
    logic [7:0] column_select;
    logic       latch_pulse;
    logic       driver_reset;
    logic       bank_select_wide;
    logic       last;
  } result_t;

endpackage

// ===== rtl/lmcs_frame_mem.sv =====
// ----------------------------------------------------------------------------
// Frame store memory
// One 24-bit word per pixel (blue, green, red), one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module lmcs_frame_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [AW-1:0]                     wr_addr_i,
  input  logic [lmcs_pkg::PIXEL_W-1:0]      wr_data_i,
  input  logic                              rd_en_i,
  input  logic [AW-1:0]                     rd_addr_i,
  output logic [lmcs_pkg::PIXEL_W-1:0]      rd_data_o
);

  logic [lmcs_pkg::PIXEL_W-1:0] mem [DEPTH];
  logic [lmcs_pkg::PIXEL_W-1:0] rd_data_q;

  // Store a pixel word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read a pixel word, hold it until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/lmcs_seq.sv =====
// ----------------------------------------------------------------------------
// Scan sequencer
// Clears the frame store after reset, stores pixel writes, and steps one
// shared counter and the row/color pointers to emit scan and init bytes.
// ----------------------------------------------------------------------------
module lmcs_seq #(
  parameter int unsigned PAGES = 4,
  parameter int unsigned PW    = 2,
  parameter int unsigned AW    = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        operation_i,
  input  logic [2:0]                        pixel_x_i,
  input  logic [2:0]                        pixel_y_i,
  input  logic [7:0]                        red_level_i,
  input  logic [7:0]                        green_level_i,
  input  logic [7:0]                        blue_level_i,
  input  logic [2:0]                        scan_column_i,
  input  logic                              cfg_we_i,
  input  logic [lmcs_pkg::PAGE_W-1:0]       cfg_wdata_i,
  output logic                              mem_wr_en_o,
  output logic [AW-1:0]                     mem_wr_addr_o,
  output logic [lmcs_pkg::PIXEL_W-1:0]      mem_wr_data_o,
  output logic                              mem_rd_en_o,
  output logic [AW-1:0]                     mem_rd_addr_o,
  input  logic [lmcs_pkg::PIXEL_W-1:0]      mem_rd_data_i,
  output lmcs_pkg::result_t                 emit_o,
  input  logic                              out_free_i
);

  localparam int unsigned DEPTH = PAGES * lmcs_pkg::ROW_WORDS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_INIT  = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [AW-1:0]                 cnt_q, cnt_d;
  logic [2:0]                    row_q, row_d;
  logic [1:0]                    color_q, color_d;
  logic [2:0]                    col_q, col_d;
  logic [PW-1:0]                 page_q, page_d;
  logic [lmcs_pkg::PAGE_W-1:0]   display_page_q;

  logic                          accept;
  logic                          page_ok;
  logic                          scan_fin;
  logic                          init_fin;
  logic                          load;
  logic [7:0]                    color_byte;
  logic [2:0]                    rd_row;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign page_ok    = ({1'b0, display_page_q} < 5'(PAGES));
  assign load       = emit_o.valid && out_free_i;
  assign scan_fin   = (row_q == 3'd0) && (color_q == lmcs_pkg::COLOR_RED);
  assign init_fin   = (cnt_q == AW'(lmcs_pkg::GAMMA_BYTES - 1));

  // Hold the page register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_page_q <= '0;
    end else if (cfg_we_i) begin
      display_page_q <= cfg_wdata_i;
    end
  end

  // Write port: zero fill during the clear pass, pixel stores otherwise
  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_wr_en_o   = 1'b1;
      mem_wr_addr_o = cnt_q;
      mem_wr_data_o = '0;
    end else begin
      mem_wr_en_o   = accept && (operation_i == lmcs_pkg::OP_WRITE) && page_ok;
      mem_wr_addr_o = {display_page_q[PW-1:0], pixel_x_i, pixel_y_i};
      mem_wr_data_o = {blue_level_i, green_level_i, red_level_i};
    end
  end

  // Read port: first row on entry, next row fetched while the red byte leaves
  assign rd_row        = (state_q == ST_READ) ? row_q : (row_q - 3'd1);
  assign mem_rd_en_o   = (state_q == ST_READ) ||
                         ((state_q == ST_EMIT) && load && (color_q == lmcs_pkg::COLOR_RED) &&
                          (row_q != 3'd0));
  assign mem_rd_addr_o = {page_q, col_q, rd_row};

  // Pick the color byte of the fetched row
  always_comb begin
    case (color_q)
      lmcs_pkg::COLOR_BLUE:  color_byte = mem_rd_data_i[23:16];
      lmcs_pkg::COLOR_GREEN: color_byte = mem_rd_data_i[15:8];
      default:               color_byte = mem_rd_data_i[7:0];
    endcase
  end

  // Build the current result
  always_comb begin
    emit_o = '0;
    if (state_q == ST_EMIT) begin
      emit_o.valid      = 1'b1;
      emit_o.shift_byte = color_byte;
      if (scan_fin) begin
        emit_o.column_select = 8'b1 << col_q;
        emit_o.latch_pulse   = 1'b1;
        emit_o.last          = 1'b1;
      end
    end else if (state_q == ST_INIT) begin
      emit_o.valid            = 1'b1;
      emit_o.shift_byte       = 8'hFF;
      emit_o.driver_reset     = 1'b1;
      emit_o.bank_select_wide = init_fin;
      emit_o.last             = init_fin;
    end
  end

  // Sequence the clear pass, scans and init runs
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    color_d = color_q;
    col_d   = col_q;
    page_d  = page_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if ((operation_i == lmcs_pkg::OP_SCAN) && page_ok) begin
            state_d = ST_READ;
            row_d   = 3'(lmcs_pkg::SIDE - 1);
            color_d = lmcs_pkg::COLOR_BLUE;
            col_d   = scan_column_i;
            page_d  = display_page_q[PW-1:0];
          end else if (operation_i == lmcs_pkg::OP_INIT) begin
            state_d = ST_INIT;
            cnt_d   = '0;
          end
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          if (color_q == lmcs_pkg::COLOR_RED) begin
            if (row_q == 3'd0) begin
              state_d = ST_IDLE;
            end else begin
              row_d   = row_q - 3'd1;
              color_d = lmcs_pkg::COLOR_BLUE;
            end
          end else begin
            color_d = color_q - 2'd1;
          end
        end
      end
      ST_INIT: begin
        if (load) begin
          cnt_d = cnt_q + AW'(1);
          if (init_fin) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      row_q   <= '0;
      color_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
      color_q <= color_d;
    end
  end

  // Hold the request's column and page
  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    page_q <= page_d;
  end

endmodule

// ===== rtl/lmcs_out_stage.sv =====
// ----------------------------------------------------------------------------
// Output register
// Holds one result for the receiver and takes the next when it is free.
// ----------------------------------------------------------------------------
module lmcs_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lmcs_pkg::result_t    emit_i,
  output logic                 out_free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           shift_byte_o,
  output logic [7:0]           column_select_o,
  output logic                 latch_pulse_o,
  output logic                 driver_reset_o,
  output logic                 bank_select_wide_o,
  output logic                 last_o
);

  logic              valid_q, valid_d;
  lmcs_pkg::result_t data_q;
  logic              take;

  assign out_free_o = !valid_q || out_ready_i;
  assign take       = emit_i.valid && out_free_o;

  // Fill on take, drop when the receiver takes it
  always_comb begin
    if (take) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= emit_i;
    end
  end

  assign out_valid_o        = valid_q;
  assign shift_byte_o       = data_q.shift_byte;
  assign column_select_o    = data_q.column_select;
  assign latch_pulse_o      = data_q.latch_pulse;
  assign driver_reset_o     = data_q.driver_reset;
  assign bank_select_wide_o = data_q.bank_select_wide;
  assign last_o             = data_q.last;

endmodule

// ===== rtl/led_matrix_column_scanner_top.sv =====
// ----------------------------------------------------------------------------
// LED matrix column scanner, top level
// Paged 8x8 RGB frame store with column scan and driver init byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid_i/in_ready_o) carry an operation: write pixel,
//   scan column or init driver. Results leave on out_valid_o/out_ready_i,
//   one byte per transfer, with last_o on the final byte of a run.
//   cfg_we_i/cfg_wdata_i set the display page, taken on any edge with the
//   write enable high; change it only while the block is idle.
//   After reset the block zeroes the frame store, one pixel per cycle, over
//   all PAGES*64 words; in_ready_o stays low during this clear pass.
//   A pixel write is stored without leaving idle. A scan reads one stored
//   pixel word per row from a single memory read port and emits 24 bytes;
//   the first byte goes through the READ state and the memory read register
//   before the output register takes it, and the rest follow one per cycle
//   while the receiver takes them. An init run emits 18 bytes. A scan with
//   the page beyond the store and an unused operation code emit nothing.
//   A stalled receiver holds the current result in the output register; the
//   sequencer waits and no byte is lost. One request is worked at a time.
// ----------------------------------------------------------------------------
module led_matrix_column_scanner_top #(
  parameter int unsigned PAGES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [2:0]                    pixel_x_i,
  input  logic [2:0]                    pixel_y_i,
  input  logic [7:0]                    red_level_i,
  input  logic [7:0]                    green_level_i,
  input  logic [7:0]                    blue_level_i,
  input  logic [2:0]                    scan_column_i,
  input  logic                          cfg_we_i,
  input  logic [lmcs_pkg::PAGE_W-1:0]   cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    shift_byte_o,
  output logic [7:0]                    column_select_o,
  output logic                          latch_pulse_o,
  output logic                          driver_reset_o,
  output logic                          bank_select_wide_o,
  output logic                          last_o
);

  localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned AW    = PW + 2 * lmcs_pkg::COORD_W;
  localparam int unsigned DEPTH = PAGES * lmcs_pkg::ROW_WORDS;

  logic                          mem_wr_en;
  logic [AW-1:0]                 mem_wr_addr;
  logic [lmcs_pkg::PIXEL_W-1:0]  mem_wr_data;
  logic                          mem_rd_en;
  logic [AW-1:0]                 mem_rd_addr;
  logic [lmcs_pkg::PIXEL_W-1:0]  mem_rd_data;
  lmcs_pkg::result_t             emit;
  logic                          out_free;

  lmcs_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  lmcs_seq #(
    .PAGES (PAGES),
    .PW    (PW),
    .AW    (AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .red_level_i   (red_level_i),
    .green_level_i (green_level_i),
    .blue_level_i  (blue_level_i),
    .scan_column_i (scan_column_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .emit_o        (emit),
    .out_free_i    (out_free)
  );

  lmcs_out_stage u_out (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .emit_i             (emit),
    .out_free_o         (out_free),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .shift_byte_o       (shift_byte_o),
    .column_select_o    (column_select_o),
    .latch_pulse_o      (latch_pulse_o),
    .driver_reset_o     (driver_reset_o),
    .bank_select_wide_o (bank_select_wide_o),
    .last_o             (last_o)
  );

endmodule

// ===== rtl/lmcs_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's result channel for consistent framing flags.
// ----------------------------------------------------------------------------
module lmcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] shift_byte_o,
  input logic [7:0] column_select_o,
  input logic       latch_pulse_o,
  input logic       driver_reset_o,
  input logic       bank_select_wide_o,
  input logic       last_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(shift_byte_o) && $stable(last_o))
    else $error("stalled result changed");

  // Latch only on a scan's last byte, with exactly one column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && latch_pulse_o |-> last_o && $onehot(column_select_o) && !driver_reset_o)
    else $error("latch without last byte or one-hot column");

  // Drive no column outside the latch byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !latch_pulse_o |-> column_select_o == 8'd0)
    else $error("column select outside latch byte");

  // Init bytes are all ones and bank select only on their last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && driver_reset_o |-> shift_byte_o == 8'hFF && bank_select_wide_o == last_o)
    else $error("bad init byte");

  // Bank select only within an init run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bank_select_wide_o |-> driver_reset_o)
    else $error("bank select outside init");

endmodule

bind led_matrix_column_scanner_top lmcs_checker u_lmcs_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .shift_byte_o       (shift_byte_o),
  .column_select_o    (column_select_o),
  .latch_pulse_o      (latch_pulse_o),
  .driver_reset_o     (driver_reset_o),
  .bank_select_wide_o (bank_select_wide_o),
  .last_o             (last_o)
);

// ===== tb/sv/column_scan_checker.sv =====
// ----------------------------------------------------------------------------
// Column scan checker
// Watches the request, configuration and result channels of the LED matrix
// column scanner. Keeps its own paged frame store and display page, expands
// each accepted request into the bytes it must produce, and compares every
// accepted result field by field against the oldest expected byte.
// ----------------------------------------------------------------------------
module column_scan_checker
  import lmcs_pkg::*;
#(
  parameter int unsigned PAGES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        operation_i,
  input  logic [2:0]        pixel_x_i,
  input  logic [2:0]        pixel_y_i,
  input  logic [7:0]        red_level_i,
  input  logic [7:0]        green_level_i,
  input  logic [7:0]        blue_level_i,
  input  logic [2:0]        scan_column_i,
  input  logic              cfg_we_i,
  input  logic [PAGE_W-1:0] cfg_wdata_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        shift_byte_i,
  input  logic [7:0]        column_select_i,
  input  logic              latch_pulse_i,
  input  logic              driver_reset_i,
  input  logic              bank_select_wide_i,
  input  logic              last_i,
  output int                mismatch_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLORS      = 3;
  localparam int unsigned COLUMN_SPAN = SIDE * COLORS;
  localparam int unsigned PAGE_BYTES  = SIDE * SIDE * COLORS;
  localparam int unsigned STORE_BYTES = PAGES * PAGE_BYTES;
  localparam int          PRINT_CAP   = 200;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic [7:0] column_select;
    logic       latch_pulse;
    logic       driver_reset;
    logic       bank_select_wide;
    logic       last;
  } scan_byte_t;

  logic [7:0]        frame_mem [STORE_BYTES];
  logic [PAGE_W-1:0] page_q;
  scan_byte_t        expected_bytes [$];
  int                mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic int unsigned pixel_addr(int unsigned page, int unsigned x,
                                             int unsigned y, int unsigned color);
    return page * PAGE_BYTES + x * COLUMN_SPAN + y * COLORS + color;
  endfunction

  // Count a mismatch and print one line for it, up to PRINT_CAP lines
  task automatic report_mismatch(string what, int unsigned exp_val, int unsigned got_val);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h",
               $realtime, what, exp_val, got_val);
    end
  endtask

  // Update the frame store or queue the bytes that one request produces
  task automatic predict_request();
    scan_byte_t  e;
    int          row;
    int          color;
    int unsigned k;
    logic        fin;
    case (operation_i)
      OP_WRITE: begin
        if (page_q < PAGES) begin
          frame_mem[pixel_addr(page_q, pixel_x_i, pixel_y_i, COLOR_RED)]   = red_level_i;
          frame_mem[pixel_addr(page_q, pixel_x_i, pixel_y_i, COLOR_GREEN)] = green_level_i;
          frame_mem[pixel_addr(page_q, pixel_x_i, pixel_y_i, COLOR_BLUE)]  = blue_level_i;
        end
      end
      OP_SCAN: begin
        if (page_q < PAGES) begin
          // Walk rows top down, blue first within each row
          for (row = SIDE - 1; row >= 0; row--) begin
            for (color = int'(COLOR_BLUE); color >= int'(COLOR_RED); color--) begin
              fin = (row == 0) && (color == int'(COLOR_RED));
              e = '0;
              e.shift_byte = frame_mem[pixel_addr(page_q, scan_column_i, row, color)];
              if (fin) begin
                e.column_select = 8'd1 << scan_column_i;
                e.latch_pulse   = 1'b1;
                e.last          = 1'b1;
              end
              expected_bytes.push_back(e);
            end
          end
        end
      end
      OP_INIT: begin
        for (k = 0; k < GAMMA_BYTES; k++) begin
          e = '0;
          e.shift_byte   = 8'hFF;
          e.driver_reset = 1'b1;
          if (k == GAMMA_BYTES - 1) begin
            e.bank_select_wide = 1'b1;
            e.last             = 1'b1;
          end
          expected_bytes.push_back(e);
        end
      end
      default: ;
    endcase
  endtask

  // Compare one delivered byte with the oldest expectation
  task automatic check_result();
    scan_byte_t e;
    if (expected_bytes.size() == 0) begin
      report_mismatch("unexpected result", 0, shift_byte_i);
    end else begin
      e = expected_bytes.pop_front();
      if (shift_byte_i !== e.shift_byte)
        report_mismatch("shift_byte", e.shift_byte, shift_byte_i);
      if (column_select_i !== e.column_select)
        report_mismatch("column_select", e.column_select, column_select_i);
      if (latch_pulse_i !== e.latch_pulse)
        report_mismatch("latch_pulse", e.latch_pulse, latch_pulse_i);
      if (driver_reset_i !== e.driver_reset)
        report_mismatch("driver_reset", e.driver_reset, driver_reset_i);
      if (bank_select_wide_i !== e.bank_select_wide)
        report_mismatch("bank_select_wide", e.bank_select_wide, bank_select_wide_i);
      if (last_i !== e.last)
        report_mismatch("last", e.last, last_i);
    end
  endtask

  // Track the block: drain results, apply page writes, then expand requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_bytes.delete();
      foreach (frame_mem[i]) frame_mem[i] = '0;
      page_q = '0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (cfg_we_i) page_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) predict_request();
      pending_o <= expected_bytes.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// LED matrix column scanner testbench
// Drives pixel writes, column scans, driver init runs and unused codes over
// several display pages, in range and beyond the store, with random gaps on
// the request side and random stalls on the result side. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lmcs_pkg::*;

  localparam int unsigned PAGES        = 4;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned TARGET_REQS  = 410;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_ready;
  logic [1:0]        operation        = OP_WRITE;
  logic [2:0]        pixel_x          = '0;
  logic [2:0]        pixel_y          = '0;
  logic [7:0]        red_level        = '0;
  logic [7:0]        green_level      = '0;
  logic [7:0]        blue_level       = '0;
  logic [2:0]        scan_column      = '0;
  logic              cfg_we           = 1'b0;
  logic [PAGE_W-1:0] cfg_wdata        = '0;
  logic              out_valid;
  logic              out_ready        = 1'b0;
  logic [7:0]        shift_byte;
  logic [7:0]        column_select;
  logic              latch_pulse;
  logic              driver_reset;
  logic              bank_select_wide;
  logic              last;

  int                mismatch_count;
  int                pending_bytes;
  int unsigned       cycle_count = 0;
  int unsigned       stall_left  = 0;
  bit                steady      = 1'b0;
  logic [PAGE_W-1:0] cur_page    = '0;
  int unsigned       useful_reqs = 0;

  always #5 clk = ~clk;

  led_matrix_column_scanner_top #(
    .PAGES(PAGES)
  ) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .operation_i        (operation),
    .pixel_x_i          (pixel_x),
    .pixel_y_i          (pixel_y),
    .red_level_i        (red_level),
    .green_level_i      (green_level),
    .blue_level_i       (blue_level),
    .scan_column_i      (scan_column),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .shift_byte_o       (shift_byte),
    .column_select_o    (column_select),
    .latch_pulse_o      (latch_pulse),
    .driver_reset_o     (driver_reset),
    .bank_select_wide_o (bank_select_wide),
    .last_o             (last)
  );

  column_scan_checker #(
    .PAGES(PAGES)
  ) checker_inst (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .operation_i        (operation),
    .pixel_x_i          (pixel_x),
    .pixel_y_i          (pixel_y),
    .red_level_i        (red_level),
    .green_level_i      (green_level),
    .blue_level_i       (blue_level),
    .scan_column_i      (scan_column),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .shift_byte_i       (shift_byte),
    .column_select_i    (column_select),
    .latch_pulse_i      (latch_pulse),
    .driver_reset_i     (driver_reset),
    .bank_select_wide_i (bank_select_wide),
    .last_i             (last),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (pending_bytes)
  );

  // Stall the result side at random, mostly briefly, never in steady phases
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 2);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_req(logic [1:0] op, logic [2:0] x, logic [2:0] y, logic [7:0] r,
                          logic [7:0] g, logic [7:0] b, logic [2:0] col);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    pixel_x     <= x;
    pixel_y     <= y;
    red_level   <= r;
    green_level <= g;
    blue_level  <= b;
    scan_column <= col;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every expected byte is out and the block settles
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_page(logic [PAGE_W-1:0] page);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= page;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_page  = page;
  endtask

  // Random request, mostly writes and scans with occasional init and unused codes
  task automatic send_random();
    int unsigned r;
    logic [1:0]  op;
    r  = $urandom_range(0, 99);
    op = (r < 55) ? OP_WRITE : (r < 88) ? OP_SCAN : (r < 96) ? OP_INIT : OP_UNUSED;
    send_req(op, 3'($urandom()), 3'($urandom()), pick_level(), pick_level(), pick_level(),
             3'($urandom()));
    if (op == OP_INIT || (cur_page < PAGES && op != OP_UNUSED)) useful_reqs++;
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    logic [PAGE_W-1:0] next_page;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Hold off until the clear pass after reset is over
    do @(posedge clk); while (!in_ready);
    set_page('0);

    // Directed: empty store, corner pixels, both edge columns, init, unused code
    send_req(OP_SCAN,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 3'd0);
    send_req(OP_WRITE, 3'd0, 3'd0, 8'hFF, 8'hFF, 8'hFF, 3'd7);
    send_req(OP_WRITE, 3'd7, 3'd7, 8'h01, 8'h80, 8'hAA, 3'd0);
    send_req(OP_WRITE, 3'd0, 3'd7, 8'h55, 8'h00, 8'hFF, 3'd0);
    send_req(OP_WRITE, 3'd7, 3'd0, 8'h12, 8'h34, 8'h56, 3'd0);
    send_req(OP_SCAN,  3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF, 3'd0);
    send_req(OP_SCAN,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 3'd7);
    send_req(OP_INIT,  3'd5, 3'd2, 8'h00, 8'h00, 8'h00, 3'd3);
    send_req(OP_UNUSED, 3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF, 3'd7);
    send_req(OP_SCAN,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 3'd5);

    // Last page in the store
    set_page(PAGE_W'(PAGES - 1));
    send_req(OP_WRITE, 3'd3, 3'd4, 8'hC3, 8'h3C, 8'h99, 3'd0);
    send_req(OP_SCAN,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 3'd3);
    send_req(OP_SCAN,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 3'd0);

    // Page beyond the store: write dropped, scan silent, init still runs
    set_page({PAGE_W{1'b1}});
    send_req(OP_WRITE, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 3'd0);
    send_req(OP_SCAN,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 3'd0);
    send_req(OP_INIT,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 3'd0);
    send_req(OP_UNUSED, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 3'd0);
    set_page(PAGE_W'(PAGES));
    send_req(OP_SCAN,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 3'd7);

    // Back on page zero, the dropped write must not show
    set_page('0);
    send_req(OP_SCAN,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 3'd0);
    send_req(OP_SCAN,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 3'd7);
    useful_reqs = 15;

    // Random phases over many page settings
    phase = 0;
    while (useful_reqs < TARGET_REQS) begin
      case (phase)
        0:       next_page = 1;
        1:       next_page = 2;
        2:       next_page = 3;
        3:       next_page = 0;
        4:       next_page = {PAGE_W{1'b1}};
        default: next_page = ($urandom_range(0, 4) == 0) ?
                             PAGE_W'($urandom_range(PAGES, (1 << PAGE_W) - 1)) :
                             PAGE_W'($urandom_range(0, PAGES - 1));
      endcase
      set_page(next_page);
      steady = (phase % 3 == 2);
      n = (cur_page < PAGES) ? 60 : 10;
      repeat (n) send_random();
      phase++;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
